@@ hdl/word_frequency_table_unit_macros.svh @@
// assertion macros for the word frequency table unit
`ifndef WORD_FREQUENCY_TABLE_UNIT_MACROS_SVH
`define WORD_FREQUENCY_TABLE_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
`define WFT_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("wft assertion failed");
`define WFT_ASSERT_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("wft forbidden condition");
`else
`define WFT_ASSERT(lbl, clk, rst, prop)
`define WFT_ASSERT_NEVER(lbl, clk, rst, cond)
`endif
`endif

@@ hdl/wft_pkg.sv @@
// types, codes and defaults shared by the word frequency table unit
package wft_pkg;
   localparam int TableEntriesDefault = 128;
   localparam int MaxWordCharsDefault = 19;
   localparam int CountBitsDefault    = 16;

   localparam logic       OP_TEXT = 1'b0;
   localparam logic       OP_READ = 1'b1;
   localparam logic       KIND_WORD = 1'b0;
   localparam logic       KIND_READ = 1'b1;
   localparam logic [1:0] ST_MATCH  = 2'd0;
   localparam logic [1:0] ST_NEW    = 2'd1;
   localparam logic [1:0] ST_FULL   = 2'd2;
   localparam logic [1:0] ST_UNUSED = 2'd3;
   localparam logic [7:0] CH_SPACE   = 8'd32;
   localparam logic [7:0] CH_NEWLINE = 8'd10;

   typedef struct packed {
      logic       opcode;
      logic [7:0] char_in;
      logic [6:0] entry_sel;
      logic [4:0] char_pos;
   } req_type;

   typedef struct packed {
      logic        result_kind;
      logic [6:0]  entry_index;
      logic [15:0] word_count;
      logic [1:0]  status;
      logic [7:0]  char_out;
      logic [4:0]  word_length;
      logic        truncated;
      logic [7:0]  entries_used;
   } rsp_type;
endpackage

@@ hdl/wft_req_if.sv @@
// request channel of the word frequency table unit
interface wft_req_if;
   import wft_pkg::*;
   logic    valid;
   logic    ready;
   req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

@@ hdl/wft_rsp_if.sv @@
// response channel of the word frequency table unit
interface wft_rsp_if;
   import wft_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

@@ hdl/wft_fifo.sv @@
// two-entry command queue between the front and back parts
module wft_fifo #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);
   logic [WIDTH-1:0] mem_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       cnt_ff, cnt_in;
   logic             push, pop;

   assign push_ready = (cnt_ff != 2'd2);
   assign pop_valid  = (cnt_ff != 2'd0);
   assign pop_data   = mem_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end
endmodule

@@ hdl/wft_front.sv @@
// front part: takes text bytes, builds words, queues lookups and reads
module wft_front #(
   parameter int MAX_WORD_CHARS = 19
) (
   input  logic clock,
   input  logic reset,
   wft_req_if.sink req_chan,
   output logic push_valid,
   input  logic push_ready,
   output logic [MAX_WORD_CHARS*8+$clog2(MAX_WORD_CHARS+1)+13:0] push_data
);
   import wft_pkg::*;

   localparam int LW = $clog2(MAX_WORD_CHARS + 1);
   localparam int W8 = MAX_WORD_CHARS * 8;

   logic [W8-1:0] word_ff, word_in;
   logic [LW-1:0] len_ff, len_in;
   logic          trunc_ff, trunc_in;
   logic          is_sep, accept;
   req_type       req;

   assign req        = req_chan.payload;
   assign is_sep     = (req.opcode == OP_TEXT) &&
                       (req.char_in == CH_SPACE || req.char_in == CH_NEWLINE);
   assign push_valid = req_chan.valid &&
                       (req.opcode == OP_READ || (is_sep && len_ff != '0));
   assign req_chan.ready = push_ready;
   assign accept     = req_chan.valid && push_ready;
   assign push_data  = {req.opcode, req.entry_sel, req.char_pos, trunc_ff, len_ff, word_ff};

   always_comb begin
      word_in  = word_ff;
      len_in   = len_ff;
      trunc_in = trunc_ff;
      if (accept && req.opcode == OP_TEXT) begin
         if (is_sep) begin
            len_in   = '0;
            trunc_in = 1'b0;
         end else if (32'(len_ff) < MAX_WORD_CHARS) begin
            for (int i = 0; i < MAX_WORD_CHARS; i++) begin
               if (32'(len_ff) == i) begin
                  word_in[i*8 +: 8] = req.char_in;
               end
            end
            len_in = len_ff + 1'b1;
         end else begin
            trunc_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff   <= '0;
         trunc_ff <= 1'b0;
      end else begin
         len_ff   <= len_in;
         trunc_ff <= trunc_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end
endmodule

@@ hdl/wft_back.sv @@
// back part: scans the word table, updates counts and answers reads
module wft_back #(
   parameter int TABLE_ENTRIES  = 128,
   parameter int MAX_WORD_CHARS = 19,
   parameter int COUNT_BITS     = 16
) (
   input  logic clock,
   input  logic reset,
   input  logic pop_valid,
   output logic pop_ready,
   input  logic [MAX_WORD_CHARS*8+$clog2(MAX_WORD_CHARS+1)+13:0] pop_data,
   wft_rsp_if.source rsp_chan
);
   import wft_pkg::*;
   `include "word_frequency_table_unit_macros.svh"

   localparam int LW    = $clog2(MAX_WORD_CHARS + 1);
   localparam int W8    = MAX_WORD_CHARS * 8;
   localparam int QW    = W8 + LW + 14;
   localparam int IDX_W = $clog2(TABLE_ENTRIES);
   localparam int UW    = $clog2(TABLE_ENTRIES + 1);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_CMP  = 3'd1;
   localparam logic [2:0] S_HIT  = 3'd2;
   localparam logic [2:0] S_NEW  = 3'd3;
   localparam logic [2:0] S_RDR  = 3'd4;
   localparam logic [2:0] S_MISS = 3'd5;

   logic [W8-1:0]         chars_mem [TABLE_ENTRIES];
   logic [LW-1:0]         len_mem   [TABLE_ENTRIES];
   logic [COUNT_BITS-1:0] cnt_mem   [TABLE_ENTRIES];

   logic [2:0]            state_ff, state_in;
   logic [QW-1:0]         cmd_ff, cmd_in;
   logic [IDX_W-1:0]      idx_ff, idx_in;
   logic [UW-1:0]         used_ff, used_in;
   logic [W8-1:0]         row_rd_ff;
   logic [LW-1:0]         len_rd_ff;
   logic [COUNT_BITS-1:0] cnt_rd_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_ff, rsp_in;

   logic                  out_free, hit, wr_new, wr_cnt;
   logic [COUNT_BITS-1:0] cnt_inc;
   logic [W8-1:0]         c_word;
   logic [LW-1:0]         c_len;
   logic                  c_trunc;
   logic [4:0]            c_pos;
   logic [6:0]            c_sel;
   logic [6:0]            h_sel;
   logic                  h_op;
   logic [7:0]            rd_char;

   assign c_word  = cmd_ff[W8-1:0];
   assign c_len   = cmd_ff[W8 +: LW];
   assign c_trunc = cmd_ff[W8+LW];
   assign c_pos   = cmd_ff[W8+LW+1 +: 5];
   assign c_sel   = cmd_ff[W8+LW+6 +: 7];
   assign h_sel   = pop_data[W8+LW+6 +: 7];
   assign h_op    = pop_data[QW-1];

   assign out_free         = !rsp_valid_ff || rsp_chan.ready;
   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_ff;
   assign pop_ready        = (state_ff == S_IDLE);

   always_comb begin
      hit = (len_rd_ff == c_len);
      for (int i = 0; i < MAX_WORD_CHARS; i++) begin
         if (i < 32'(c_len) && row_rd_ff[i*8 +: 8] != c_word[i*8 +: 8]) begin
            hit = 1'b0;
         end
      end
      rd_char = 8'd0;
      for (int i = 0; i < MAX_WORD_CHARS; i++) begin
         if (32'(c_pos) == i && i < 32'(len_rd_ff)) begin
            rd_char = row_rd_ff[i*8 +: 8];
         end
      end
      cnt_inc = (cnt_rd_ff == {COUNT_BITS{1'b1}}) ? cnt_rd_ff : cnt_rd_ff + 1'b1;
   end

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      idx_in       = idx_ff;
      used_in      = used_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_in       = rsp_ff;
      wr_new       = 1'b0;
      wr_cnt       = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (pop_valid) begin
               cmd_in = pop_data;
               if (h_op == OP_READ) begin
                  if (16'(h_sel) < 16'(used_ff)) begin
                     idx_in   = IDX_W'(h_sel);
                     state_in = S_RDR;
                  end else begin
                     state_in = S_MISS;
                  end
               end else if (used_ff == '0) begin
                  state_in = S_NEW;
               end else begin
                  idx_in   = '0;
                  state_in = S_CMP;
               end
            end
         end
         S_CMP: begin
            if (hit) begin
               state_in = S_HIT;
            end else if (UW'(idx_ff) + 1'b1 == used_ff) begin
               state_in = S_NEW;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         S_HIT: begin
            if (out_free) begin
               wr_cnt       = 1'b1;
               rsp_valid_in = 1'b1;
               rsp_in       = '{KIND_WORD, 7'(idx_ff), 16'(cnt_inc), ST_MATCH, 8'd0,
                                5'(c_len), c_trunc, 8'(used_ff)};
               state_in     = S_IDLE;
            end
         end
         S_NEW: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (used_ff == UW'(TABLE_ENTRIES)) begin
                  rsp_in = '{KIND_WORD, 7'd0, 16'd0, ST_FULL, 8'd0,
                             5'(c_len), c_trunc, 8'(used_ff)};
               end else begin
                  wr_new  = 1'b1;
                  used_in = used_ff + 1'b1;
                  rsp_in  = '{KIND_WORD, 7'(used_ff), 16'd1, ST_NEW, 8'd0,
                              5'(c_len), c_trunc, 8'(used_in)};
               end
               state_in = S_IDLE;
            end
         end
         S_RDR: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '{KIND_READ, c_sel, 16'(cnt_rd_ff), ST_MATCH, rd_char,
                                5'(len_rd_ff), 1'b0, 8'(used_ff)};
               state_in     = S_IDLE;
            end
         end
         S_MISS: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '{KIND_READ, c_sel, 16'd0, ST_UNUSED, 8'd0,
                                5'd0, 1'b0, 8'(used_ff)};
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      idx_ff <= idx_in;
      rsp_ff <= rsp_in;
   end

   // table storage, registered reads at the next scan address
   always_ff @(posedge clock) begin
      if (wr_new) begin
         chars_mem[IDX_W'(used_ff)] <= c_word;
         len_mem[IDX_W'(used_ff)]   <= c_len;
         cnt_mem[IDX_W'(used_ff)]   <= COUNT_BITS'(1);
      end else if (wr_cnt) begin
         cnt_mem[idx_ff] <= cnt_inc;
      end
      row_rd_ff <= chars_mem[idx_in];
      len_rd_ff <= len_mem[idx_in];
      cnt_rd_ff <= cnt_mem[idx_in];
   end

   `WFT_ASSERT_NEVER(a_used_bound, clock, reset, used_ff > UW'(TABLE_ENTRIES))
   `WFT_ASSERT(a_new_grows, clock, reset, (state_ff == S_NEW && out_free && used_ff != UW'(TABLE_ENTRIES)) |=> (used_ff == UW'($past(used_ff) + 1'b1)))
   `WFT_ASSERT(a_scan_in_range, clock, reset, (state_ff == S_CMP) |-> (UW'(idx_ff) < used_ff))
   `WFT_ASSERT_NEVER(a_rsp_overwrite, clock, reset, rsp_valid_ff && !rsp_chan.ready && state_ff != S_IDLE && state_ff != S_CMP && state_in == S_IDLE)
endmodule

@@ hdl/word_frequency_table_unit.sv @@
// word frequency table unit: top level
// order: a text byte or separator is taken while the queue has room; a finished word's
// response is registered after the back part scans the entries in use (one per cycle)
// flow: one request per cycle while the two-entry queue has room; the back part takes a
// new lookup or read from the queue only once it is back in idle
// reset: synchronous, clears the word in progress, the entry count and the queue
module word_frequency_table_unit #(
   parameter int TABLE_ENTRIES  = wft_pkg::TableEntriesDefault,
   parameter int MAX_WORD_CHARS = wft_pkg::MaxWordCharsDefault,
   parameter int COUNT_BITS     = wft_pkg::CountBitsDefault
) (
   input  logic clock,
   input  logic reset,
   wft_req_if.sink   req_chan,
   wft_rsp_if.source rsp_chan
);
   localparam int QW = MAX_WORD_CHARS * 8 + $clog2(MAX_WORD_CHARS + 1) + 14;

   logic          push_valid, push_ready, pop_valid, pop_ready;
   logic [QW-1:0] push_data, pop_data;

   wft_front #(.MAX_WORD_CHARS(MAX_WORD_CHARS)) u_front (
      .clock(clock), .reset(reset), .req_chan(req_chan),
      .push_valid(push_valid), .push_ready(push_ready), .push_data(push_data)
   );

   wft_fifo #(.WIDTH(QW)) u_fifo (
      .clock(clock), .reset(reset),
      .push_valid(push_valid), .push_ready(push_ready), .push_data(push_data),
      .pop_valid(pop_valid), .pop_ready(pop_ready), .pop_data(pop_data)
   );

   wft_back #(
      .TABLE_ENTRIES(TABLE_ENTRIES), .MAX_WORD_CHARS(MAX_WORD_CHARS),
      .COUNT_BITS(COUNT_BITS)
   ) u_back (
      .clock(clock), .reset(reset),
      .pop_valid(pop_valid), .pop_ready(pop_ready), .pop_data(pop_data),
      .rsp_chan(rsp_chan)
   );
endmodule

@@ test/tb_word_frequency_table_unit.sv @@
// testbench for the word frequency table unit: directed and random text and reads checked against a table predictor
`timescale 1ns / 1ps
module tb_word_frequency_table_unit;
   import wft_pkg::*;

   localparam int NumEntries = 128;
   localparam int MaxChars   = 19;

   logic clock = 1'b0;
   logic reset = 1'b1;

   wft_req_if req_chan ();
   wft_rsp_if rsp_chan ();

   word_frequency_table_unit dut (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_chan.sink),
      .rsp_chan(rsp_chan.source)
   );

   always #6 clock = ~clock;

   // predictor state
   logic [7:0]  tbl_chars [NumEntries][MaxChars];
   logic [4:0]  tbl_len [NumEntries];
   logic [15:0] tbl_count [NumEntries];
   int          tbl_used;
   logic [7:0]  word_buf [MaxChars];
   int          word_len;
   bit          word_cut;

   req_type pending_reqs[$];
   rsp_type expected_rsps[$];
   int      failures;
   bit      stim_done;
   int      send_gap;
   int      recv_gap;
   bit      req_taken;

   function automatic rsp_type make_rsp(logic k, int idx, logic [15:0] cnt, logic [1:0] st,
                                        logic [7:0] ch, int len, logic tr);
      rsp_type r;
      r.result_kind  = k;
      r.entry_index  = idx[6:0];
      r.word_count   = cnt;
      r.status       = st;
      r.char_out     = ch;
      r.word_length  = len[4:0];
      r.truncated    = tr;
      r.entries_used = tbl_used[7:0];
      return r;
   endfunction

   task automatic count_request(input req_type q);
      int  hit;
      bit  same;
      int  len;
      logic tr;
      hit = -1;
      if (q.opcode == OP_TEXT) begin
         if (q.char_in == CH_SPACE || q.char_in == CH_NEWLINE) begin
            if (word_len == 0) return;
            len = word_len;
            tr = word_cut;
            word_len = 0;
            word_cut = 0;
            for (int e = 0; e < tbl_used && hit < 0; e++) begin
               same = (tbl_len[e] == len);
               for (int i = 0; i < len; i++)
                  if (tbl_chars[e][i] != word_buf[i]) same = 0;
               if (same) hit = e;
            end
            if (hit >= 0) begin
               if (tbl_count[hit] != 16'hffff) tbl_count[hit]++;
               expected_rsps.push_back(make_rsp(KIND_WORD, hit, tbl_count[hit], ST_MATCH,
                                                8'd0, len, tr));
            end else if (tbl_used < NumEntries) begin
               for (int i = 0; i < len; i++) tbl_chars[tbl_used][i] = word_buf[i];
               tbl_len[tbl_used] = len[4:0];
               tbl_count[tbl_used] = 16'd1;
               tbl_used++;
               expected_rsps.push_back(make_rsp(KIND_WORD, tbl_used - 1, 16'd1, ST_NEW,
                                                8'd0, len, tr));
            end else begin
               expected_rsps.push_back(make_rsp(KIND_WORD, 0, 16'd0, ST_FULL, 8'd0, len, tr));
            end
         end else if (word_len < MaxChars) begin
            word_buf[word_len] = q.char_in;
            word_len++;
         end else begin
            word_cut = 1;
         end
      end else if (q.entry_sel < tbl_used) begin
         expected_rsps.push_back(make_rsp(KIND_READ, q.entry_sel, tbl_count[q.entry_sel],
            ST_MATCH, (q.char_pos < tbl_len[q.entry_sel]) ?
            tbl_chars[q.entry_sel][q.char_pos] : 8'd0, tbl_len[q.entry_sel], 1'b0));
      end else begin
         expected_rsps.push_back(make_rsp(KIND_READ, q.entry_sel, 16'd0, ST_UNUSED, 8'd0, 0,
                                          1'b0));
      end
   endtask

   function automatic req_type text_req(logic [7:0] c);
      req_type q;
      q.opcode = OP_TEXT;
      q.char_in = c;
      q.entry_sel = 7'($urandom);
      q.char_pos = 5'($urandom);
      return q;
   endfunction

   function automatic req_type read_req(int sel, int pos);
      req_type q;
      q.opcode = OP_READ;
      q.char_in = 8'($urandom);
      q.entry_sel = sel[6:0];
      q.char_pos = pos[4:0];
      return q;
   endfunction

   task automatic queue_word(input string w);
      for (int i = 0; i < w.len(); i++) pending_reqs.push_back(text_req(w[i]));
      pending_reqs.push_back(text_req($urandom_range(0, 1) ? CH_SPACE : CH_NEWLINE));
   endtask

   // random word from a small vocabulary so that repeats are common
   function automatic string vocab_word(int sz);
      string s;
      int n;
      s = "";
      n = $urandom_range(1, sz);
      for (int i = 0; i < n; i++) s = {s, string'(8'($urandom_range(97, 99)))};
      return s;
   endfunction

   // request taken at the last rising edge
   always @(posedge clock) begin
      req_taken <= !reset && req_chan.valid && req_chan.ready;
   end

   // driver
   always @(negedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
         req_chan.payload <= '0;
      end else if (req_chan.valid && !req_taken) begin
      end else if (send_gap > 0) begin
         send_gap <= send_gap - 1;
         req_chan.valid <= 1'b0;
      end else if (pending_reqs.size() > 0 && pending_reqs[0].opcode !== 1'bx) begin
         req_chan.payload <= pending_reqs.pop_front();
         req_chan.valid <= 1'b1;
         send_gap <= $urandom_range(0, 3) * $urandom_range(0, 1);
      end else begin
         req_chan.valid <= 1'b0;
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else if (recv_gap > 0) begin
         recv_gap <= recv_gap - 1;
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= 1'b1;
         if (rsp_chan.valid) recv_gap <= $urandom_range(0, 3) * $urandom_range(0, 1);
      end
   end

   // monitor
   always @(posedge clock) begin
      rsp_type got;
      rsp_type want;
      if (!reset && req_chan.valid && req_chan.ready) count_request(req_chan.payload);
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got = rsp_chan.payload;
         if (expected_rsps.size() == 0) begin
            $error("unexpected response %p", got);
            failures++;
         end else begin
            want = expected_rsps.pop_front();
            if (got.result_kind !== want.result_kind) begin
               $error("result_kind exp %0d got %0d", want.result_kind, got.result_kind);
               failures++;
            end
            if (got.entry_index !== want.entry_index) begin
               $error("entry_index exp %0d got %0d", want.entry_index, got.entry_index);
               failures++;
            end
            if (got.word_count !== want.word_count) begin
               $error("word_count exp %0d got %0d", want.word_count, got.word_count);
               failures++;
            end
            if (got.status !== want.status) begin
               $error("status exp %0d got %0d", want.status, got.status);
               failures++;
            end
            if (got.char_out !== want.char_out) begin
               $error("char_out exp %0d got %0d", want.char_out, got.char_out);
               failures++;
            end
            if (got.word_length !== want.word_length) begin
               $error("word_length exp %0d got %0d", want.word_length, got.word_length);
               failures++;
            end
            if (got.truncated !== want.truncated) begin
               $error("truncated exp %0d got %0d", want.truncated, got.truncated);
               failures++;
            end
            if (got.entries_used !== want.entries_used) begin
               $error("entries_used exp %0d got %0d", want.entries_used, got.entries_used);
               failures++;
            end
         end
      end
   end

   task automatic wait_drained;
      while (pending_reqs.size() > 0 || req_chan.valid || expected_rsps.size() > 0)
         @(posedge clock);
   endtask

   initial begin
      string w;
      tbl_used = 0;
      word_len = 0;
      word_cut = 0;
      failures = 0;
      send_gap = 0;
      recv_gap = 0;
      stim_done = 0;
      req_chan.valid = 1'b0;
      req_chan.payload = '0;
      rsp_chan.ready = 1'b0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: empty tokens, unused reads, odd bytes, long word, repeats
      pending_reqs.push_back(text_req(CH_SPACE));
      pending_reqs.push_back(text_req(CH_NEWLINE));
      pending_reqs.push_back(read_req(0, 0));
      pending_reqs.push_back(read_req(127, 31));
      queue_word({8'hff, 8'h00, 8'h01, 8'h7f});
      queue_word("Ab");
      queue_word("ab");
      queue_word("Ab");
      queue_word("abcdefghijklmnopqrstuvw");
      queue_word("abcdefghijklmnopqrs");
      pending_reqs.push_back(read_req(0, 0));
      pending_reqs.push_back(read_req(0, 3));
      pending_reqs.push_back(read_req(0, 4));
      pending_reqs.push_back(read_req(3, 18));
      pending_reqs.push_back(read_req(3, 31));
      pending_reqs.push_back(read_req(4, 0));
      wait_drained();

      // random text, mostly short repeated words, plus reads and noise
      for (int n = 0; n < 300; ) begin
         case ($urandom_range(0, 9))
            0: begin
               pending_reqs.push_back(read_req($urandom_range(0, tbl_used + 2) % 128,
                                               $urandom_range(0, 31)));
               n++;
            end
            1: begin
               pending_reqs.push_back(text_req(8'($urandom)));
               n++;
            end
            2: begin
               w = "";
               for (int i = $urandom_range(1, 24); i > 0; i--)
                  w = {w, string'(8'($urandom_range(33, 255)))};
               queue_word(w);
               n += w.len() + 1;
            end
            default: begin
               w = vocab_word(4);
               queue_word(w);
               n += w.len() + 1;
            end
         endcase
         if (n > 150 && n < 170) wait_drained();
      end
      wait_drained();

      // fill the table to overflow, then read every entry
      for (int i = 0; i < 140; i++) queue_word($sformatf("z%0d", i));
      for (int i = 0; i < 128; i++) pending_reqs.push_back(read_req(i, $urandom_range(0, 3)));
      wait_drained();
      repeat (200) @(posedge clock);
      stim_done = 1;
      if (failures == 0 && expected_rsps.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   initial begin
      #40ms;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end
endmodule
